FILE: rtl/fhd_pkg.sv
// Package for the frame header hunt deframer: phase type, result type,
// header constants, codes and the expected-header-byte function.
// No dependencies; the deframer top level and the testbench import it.
package fhd_pkg;

  // Byte that opens a header and restarts a header match.
  localparam logic [7:0] SYNC_BYTE = 8'hAC;
  // Byte that closes the header.
  localparam logic [7:0] END_BYTE  = 8'hDC;
  // Last header body position (the closing byte).
  localparam logic [2:0] HDR_LAST_POS = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VERSION_MAJOR = 2'd0;
  localparam logic [1:0] CFG_VERSION_MINOR = 2'd1;
  localparam logic [1:0] CFG_MAX_TRIES     = 2'd2;
  localparam logic [1:0] CFG_MAX_LENGTH    = 2'd3;

  // Input action codes.
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_TIMEOUT  = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

  // Special negative lengths.
  localparam logic [31:0] LEN_NEG_ONE = 32'hFFFF_FFFF;
  localparam logic [31:0] LEN_NEG_TWO = 32'hFFFF_FFFE;

  // Deframer phase.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_LENGTH,
    PH_COMMAND,
    PH_PAYLOAD
  } phase_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic        last_byte;
    logic [7:0]  command;
    logic [15:0] length;
    logic [1:0]  error_code;
  } res_t;

  // Expected byte at a header body position; the version bytes come
  // from configuration.
  function automatic logic [7:0] hdr_expected(input logic [2:0] pos,
                                              input logic [7:0] ver_major,
                                              input logic [7:0] ver_minor);
    logic [7:0] exp_byte;
    case (pos)
      3'd0:    exp_byte = 8'h46;
      3'd1:    exp_byte = 8'h72;
      3'd2:    exp_byte = 8'h41;
      3'd3:    exp_byte = 8'h6E;
      3'd4:    exp_byte = ver_major;
      3'd5:    exp_byte = ver_minor;
      default: exp_byte = END_BYTE;
    endcase
    return exp_byte;
  endfunction

endpackage

FILE: rtl/fhd_in_if.sv
// Input channel of the deframer: valid/ready handshake carrying one
// received byte or a timeout event. No dependencies.
interface fhd_in_if ();
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, action, byte_value, input ready);
  modport sink   (input valid, action, byte_value, output ready);
endinterface

FILE: rtl/fhd_out_if.sv
// Result channel of the deframer: valid/ready handshake carrying one
// payload byte, completion or error item. No dependencies.
interface fhd_out_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic        last_byte;
  logic [7:0]  command;
  logic [15:0] length;
  logic [1:0]  error_code;

  modport source (output valid, kind, payload_byte, byte_index, last_byte, command,
                  length, error_code, input ready);
  modport sink   (input valid, kind, payload_byte, byte_index, last_byte, command,
                  length, error_code, output ready);
endinterface

FILE: rtl/frame_header_hunt_deframer_unit.sv
// Frame header hunt deframer: top level with input register, phase logic
// and result register. Depends on fhd_pkg, fhd_in_if and fhd_out_if.
//
//   Channel   Direction  Handshake          Carries
//   in_item   sink       valid/ready        action, byte_value
//   out_res   source     valid/ready        kind, payload_byte, byte_index,
//                                           last_byte, command, length, error_code
//   cfg_*     sink       write enable only  cfg_index, cfg_data (16 bits)
//
// An item is captured in the input register at its accepting edge and is
// evaluated against the phase state while held there; its result (if any)
// lands in the result register when the evaluation stage moves, and is
// offered from there. One item per cycle is sustained while results are taken.
// The result register sets the pace: while it holds an untaken result, the
// input register holds its item and in_item.ready falls once both are full.
// rst_n is synchronous and active low; it returns the block to hunting with
// the phase, configuration and valid registers reset and both stages empty.
module frame_header_hunt_deframer_unit import fhd_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  fhd_in_if.sink      in_item,
  fhd_out_if.source   out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Largest length that the count width can carry.
  localparam logic [31:0] LEN_CAP = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  // Configuration registers.
  logic [7:0]  ver_major_r;
  logic [7:0]  ver_minor_r;
  logic [7:0]  max_tries_r;
  logic [15:0] max_length_r;

  // Input register stage.
  logic       s0_v_r;
  logic       s0_tmo_r;
  logic [7:0] s0_b_r;

  // Phase state.
  phase_t                 phase_r, phase_nxt;
  logic [2:0]             hdr_pos_r, hdr_pos_nxt;
  logic [7:0]             tries_r, tries_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [1:0]             lcnt_r, lcnt_nxt;
  logic [7:0]             cmd_r, cmd_nxt;
  logic [LENGTH_BITS-1:0] pcnt_r, pcnt_nxt;

  // Result register.
  logic res_v_r;
  res_t res_r;
  logic emit;
  res_t res_nxt;

  // Shared decode.
  logic        adv;
  logic        step;
  logic        is_sync;
  logic        hdr_match;
  logic [31:0] acc_or;
  logic [31:0] len_limit;
  logic        too_long;
  logic [31:0] idx_ext;
  logic        last_pay;
  logic [1:0]  neg_code;

  // The evaluation stage moves whenever the result register can take a result.
  assign adv          = !res_v_r || out_res.ready;
  assign step         = s0_v_r && adv;
  assign in_item.ready = !s0_v_r || adv;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_major_r  <= 8'd1;
      ver_minor_r  <= 8'd0;
      max_tries_r  <= 8'd8;
      max_length_r <= 16'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERSION_MAJOR: ver_major_r  <= cfg_data[7:0];
        CFG_VERSION_MINOR: ver_minor_r  <= cfg_data[7:0];
        CFG_MAX_TRIES:     max_tries_r  <= cfg_data[7:0];
        CFG_MAX_LENGTH:    max_length_r <= cfg_data;
        default:           max_length_r <= max_length_r;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_item.valid && in_item.ready) begin
      s0_v_r <= 1'b1;
    end else if (adv) begin
      s0_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s0_tmo_r <= in_item.action;
      s0_b_r   <= in_item.byte_value;
    end
  end

  // Byte tests, length assembly and limit checks.
  assign is_sync   = (s0_tmo_r == ACT_BYTE) && (s0_b_r == SYNC_BYTE);
  assign hdr_match = s0_b_r == hdr_expected(hdr_pos_r, ver_major_r, ver_minor_r);
  assign acc_or    = acc_r | (32'(s0_b_r) << {lcnt_r, 3'b000});
  assign len_limit = (32'(max_length_r) < LEN_CAP) ? 32'(max_length_r) : LEN_CAP;
  assign too_long  = !acc_or[31] && (acc_or > len_limit);
  assign idx_ext   = 32'(pcnt_r);
  assign last_pay  = (idx_ext + 32'd1) >= acc_r;

  always_comb begin
    if (acc_r == LEN_NEG_ONE) begin
      neg_code = ERR_TIMEOUT;
    end else if (acc_r == LEN_NEG_TWO) begin
      neg_code = ERR_TOO_LONG;
    end else begin
      neg_code = ERR_UNKNOWN;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt   = phase_r;
    hdr_pos_nxt = hdr_pos_r;
    tries_nxt   = tries_r;
    acc_nxt     = acc_r;
    lcnt_nxt    = lcnt_r;
    cmd_nxt     = cmd_r;
    pcnt_nxt    = pcnt_r;
    case (phase_r)
      PH_HUNT: begin
        if (is_sync && max_tries_r != 8'd0) begin
          phase_nxt   = PH_HEADER;
          hdr_pos_nxt = 3'd0;
          tries_nxt   = 8'd1;
        end
      end
      PH_HEADER: begin
        if (s0_tmo_r == ACT_TIMEOUT) begin
          phase_nxt = PH_HUNT;
        end else if (is_sync) begin
          if (tries_r >= max_tries_r) begin
            phase_nxt = PH_HUNT;
          end else begin
            tries_nxt   = tries_r + 8'd1;
            hdr_pos_nxt = 3'd0;
          end
        end else if (!hdr_match) begin
          phase_nxt = PH_HUNT;
        end else if (hdr_pos_r >= HDR_LAST_POS) begin
          phase_nxt   = PH_LENGTH;
          hdr_pos_nxt = 3'd0;
          tries_nxt   = 8'd0;
          acc_nxt     = '0;
          lcnt_nxt    = 2'd0;
        end else begin
          hdr_pos_nxt = hdr_pos_r + 3'd1;
        end
      end
      PH_LENGTH: begin
        if (s0_tmo_r == ACT_TIMEOUT) begin
          phase_nxt = PH_HUNT;
        end else begin
          acc_nxt  = acc_or;
          lcnt_nxt = lcnt_r + 2'd1;
          if (lcnt_r == 2'd3) begin
            phase_nxt = too_long ? PH_HUNT : PH_COMMAND;
          end
        end
      end
      PH_COMMAND: begin
        if (s0_tmo_r == ACT_TIMEOUT) begin
          phase_nxt = PH_HUNT;
        end else begin
          cmd_nxt = s0_b_r;
          if (acc_r[31] || acc_r == '0) begin
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = PH_PAYLOAD;
            pcnt_nxt  = '0;
          end
        end
      end
      PH_PAYLOAD: begin
        if (s0_tmo_r == ACT_TIMEOUT || last_pay) begin
          phase_nxt = PH_HUNT;
        end else begin
          pcnt_nxt = pcnt_r + LENGTH_BITS'(1);
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    // Every return to hunting clears the match state.
    if (phase_nxt == PH_HUNT) begin
      hdr_pos_nxt = 3'd0;
      tries_nxt   = 8'd0;
      acc_nxt     = '0;
      lcnt_nxt    = 2'd0;
      pcnt_nxt    = '0;
    end
  end

  // Result for the item under evaluation.
  always_comb begin
    emit    = 1'b0;
    res_nxt = '0;
    case (phase_r)
      PH_LENGTH: begin
        if (s0_tmo_r == ACT_TIMEOUT) begin
          emit               = 1'b1;
          res_nxt.kind       = KIND_ERROR;
          res_nxt.error_code = ERR_TIMEOUT;
        end else if (lcnt_r == 2'd3 && too_long) begin
          emit               = 1'b1;
          res_nxt.kind       = KIND_ERROR;
          res_nxt.error_code = ERR_TOO_LONG;
        end
      end
      PH_COMMAND: begin
        if (s0_tmo_r == ACT_TIMEOUT) begin
          emit               = 1'b1;
          res_nxt.kind       = KIND_ERROR;
          res_nxt.error_code = ERR_TIMEOUT;
        end else if (acc_r[31]) begin
          emit               = 1'b1;
          res_nxt.kind       = KIND_ERROR;
          res_nxt.error_code = neg_code;
        end else if (acc_r == '0) begin
          emit              = 1'b1;
          res_nxt.kind      = KIND_DONE;
          res_nxt.last_byte = 1'b1;
          res_nxt.command   = s0_b_r;
        end
      end
      PH_PAYLOAD: begin
        emit = 1'b1;
        if (s0_tmo_r == ACT_TIMEOUT) begin
          res_nxt.kind       = KIND_ERROR;
          res_nxt.error_code = ERR_TIMEOUT;
        end else begin
          res_nxt.kind         = KIND_PAYLOAD;
          res_nxt.payload_byte = s0_b_r;
          res_nxt.byte_index   = idx_ext[15:0];
          res_nxt.last_byte    = last_pay;
          res_nxt.command      = cmd_r;
          res_nxt.length       = acc_r[15:0];
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Phase state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hdr_pos_r <= 3'd0;
      tries_r   <= 8'd0;
      acc_r     <= '0;
      lcnt_r    <= 2'd0;
      cmd_r     <= 8'd0;
      pcnt_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      hdr_pos_r <= hdr_pos_nxt;
      tries_r   <= tries_nxt;
      acc_r     <= acc_nxt;
      lcnt_r    <= lcnt_nxt;
      cmd_r     <= cmd_nxt;
      pcnt_r    <= pcnt_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (adv) begin
      res_v_r <= s0_v_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid        = res_v_r;
  assign out_res.kind         = res_r.kind;
  assign out_res.payload_byte = res_r.payload_byte;
  assign out_res.byte_index   = res_r.byte_index;
  assign out_res.last_byte    = res_r.last_byte;
  assign out_res.command      = res_r.command;
  assign out_res.length       = res_r.length;
  assign out_res.error_code   = res_r.error_code;

  // A payload phase always holds a positive length with the count inside it.
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> !acc_r[31] && (idx_ext < acc_r))
    else $error("payload phase with invalid length or count");

  // Inside a header the match position and attempt count stay in range.
  a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> hdr_pos_r <= HDR_LAST_POS && tries_r != 8'd0)
    else $error("header match state out of range");

  // A pending error result means the block has gone back to hunting.
  a_error_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && res_r.kind == KIND_ERROR |-> phase_r == PH_HUNT)
    else $error("error result without return to hunting");

  // A completed message leaves the block hunting.
  a_last_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && res_r.last_byte |-> phase_r == PH_HUNT)
    else $error("message end without return to hunting");

endmodule

FILE: verif/frame_header_hunt_deframer_unit_test.sv
// Self-checking testbench for the frame header hunt deframer: random framed
// byte streams with timeouts, checked item by item against a scoreboard.
// Depends on fhd_pkg, fhd_in_if, fhd_out_if and frame_header_hunt_deframer_unit.
import fhd_pkg::*;

// Tracks the deframer state, predicts each result and checks the block's output.
class deframer_scoreboard;
  logic [7:0]  ver_major;
  logic [7:0]  ver_minor;
  logic [7:0]  max_tries;
  logic [15:0] max_len;
  logic [31:0] len_cap;

  phase_t      phase;
  logic [2:0]  hdr_pos;
  logic [7:0]  tries;
  logic [31:0] len_acc;
  logic [1:0]  len_cnt;
  logic [7:0]  cmd_reg;
  logic [15:0] pay_cnt;

  res_t        due_results[$];
  int          errors;

  function new(int length_bits);
    len_cap   = (32'd1 << length_bits) - 32'd1;
    ver_major = 8'd1;
    ver_minor = 8'd0;
    max_tries = 8'd8;
    max_len   = 16'd64;
    cmd_reg   = 8'd0;
    errors    = 0;
    back_to_hunt();
  endfunction

  function void back_to_hunt();
    phase   = PH_HUNT;
    hdr_pos = 3'd0;
    tries   = 8'd0;
    len_acc = 32'd0;
    len_cnt = 2'd0;
    pay_cnt = 16'd0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      CFG_VERSION_MAJOR: ver_major = data[7:0];
      CFG_VERSION_MINOR: ver_minor = data[7:0];
      CFG_MAX_TRIES:     max_tries = data[7:0];
      default:           max_len   = data;
    endcase
  endfunction

  // Byte the header expects after the sync byte at a given body position.
  function logic [7:0] header_byte(logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h46;
      3'd1:    return 8'h72;
      3'd2:    return 8'h41;
      3'd3:    return 8'h6E;
      3'd4:    return ver_major;
      3'd5:    return ver_minor;
      default: return END_BYTE;
    endcase
  endfunction

  function logic [31:0] len_limit();
    return ({16'd0, max_len} < len_cap) ? {16'd0, max_len} : len_cap;
  endfunction

  function bit flag_error(logic [1:0] code, output res_t r);
    back_to_hunt();
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return 1'b1;
  endfunction

  // Advances the deframer by one item; returns 1 when it yields a result.
  function bit deframe_item(logic act, logic [7:0] b, output res_t r);
    logic [31:0] next_idx;
    r = '0;
    case (phase)
      PH_HUNT: begin
        if (act == ACT_BYTE && b == SYNC_BYTE && max_tries != 8'd0) begin
          phase   = PH_HEADER;
          hdr_pos = 3'd0;
          tries   = 8'd1;
        end
        return 1'b0;
      end
      PH_HEADER: begin
        if (act == ACT_TIMEOUT) begin
          back_to_hunt();
          return 1'b0;
        end
        // A sync byte inside the header starts a fresh attempt while any remain.
        if (b == SYNC_BYTE) begin
          if (tries >= max_tries) begin
            back_to_hunt();
          end else begin
            tries   = tries + 8'd1;
            hdr_pos = 3'd0;
          end
          return 1'b0;
        end
        if (b != header_byte(hdr_pos)) begin
          back_to_hunt();
          return 1'b0;
        end
        if (hdr_pos >= HDR_LAST_POS) begin
          phase   = PH_LENGTH;
          hdr_pos = 3'd0;
          tries   = 8'd0;
          len_acc = 32'd0;
          len_cnt = 2'd0;
        end else begin
          hdr_pos = hdr_pos + 3'd1;
        end
        return 1'b0;
      end
      PH_LENGTH: begin
        if (act == ACT_TIMEOUT) return flag_error(ERR_TIMEOUT, r);
        len_acc = len_acc | (32'(b) << (8 * len_cnt));
        if (len_cnt < 2'd3) begin
          len_cnt = len_cnt + 2'd1;
          return 1'b0;
        end
        len_cnt = 2'd0;
        // Positive lengths over the limit are refused before the command byte.
        if (!len_acc[31] && len_acc > len_limit()) return flag_error(ERR_TOO_LONG, r);
        phase = PH_COMMAND;
        return 1'b0;
      end
      PH_COMMAND: begin
        if (act == ACT_TIMEOUT) return flag_error(ERR_TIMEOUT, r);
        cmd_reg = b;
        if (len_acc[31]) begin
          if (len_acc == LEN_NEG_ONE) return flag_error(ERR_TIMEOUT, r);
          if (len_acc == LEN_NEG_TWO) return flag_error(ERR_TOO_LONG, r);
          return flag_error(ERR_UNKNOWN, r);
        end
        if (len_acc == 32'd0) begin
          back_to_hunt();
          r.kind      = KIND_DONE;
          r.last_byte = 1'b1;
          r.command   = cmd_reg;
          return 1'b1;
        end
        phase   = PH_PAYLOAD;
        pay_cnt = 16'd0;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        if (act == ACT_TIMEOUT) return flag_error(ERR_TIMEOUT, r);
        next_idx       = {16'd0, pay_cnt} + 32'd1;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.byte_index   = pay_cnt;
        r.last_byte    = (next_idx >= len_acc);
        r.command      = cmd_reg;
        r.length       = len_acc[15:0];
        if (r.last_byte) back_to_hunt();
        else pay_cnt = next_idx[15:0];
        return 1'b1;
      end
      default: begin
        back_to_hunt();
        return 1'b0;
      end
    endcase
  endfunction

  function void note_item(logic act, logic [7:0] b);
    res_t r;
    if (deframe_item(act, b, r)) due_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (due_results.size() == 0) begin
      $error("result item with none expected: kind %0d", got.kind);
      errors++;
      return;
    end
    want = due_results.pop_front();
    compare_field("kind", 32'(want.kind), 32'(got.kind));
    compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    compare_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
    compare_field("last_byte", 32'(want.last_byte), 32'(got.last_byte));
    compare_field("command", 32'(want.command), 32'(got.command));
    compare_field("length", 32'(want.length), 32'(got.length));
    compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
  endfunction

  function int pending();
    return due_results.size();
  endfunction
endclass

module frame_header_hunt_deframer_unit_test;
  localparam int LENGTH_BITS    = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  fhd_in_if  in_ch ();
  fhd_out_if out_ch ();

  deframer_scoreboard sb;

  int burst_left  = 0;
  int items_sent  = 0;
  int idle_cycles = 0;
  int stall_mode  = 0;
  int mode_cycles = 0;

  frame_header_hunt_deframer_unit #(.LENGTH_BITS(LENGTH_BITS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls: always ready, coin toss, mostly stalled or periodic,
  // changing mode at random intervals.
  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      mode_cycles <= $urandom_range(20, 120);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= (mode_cycles % 4 != 0);
    endcase
  end

  // Both channels are observed here; the watchdog ends a run that stops moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(res_t'{kind: out_ch.kind, payload_byte: out_ch.payload_byte,
                               byte_index: out_ch.byte_index, last_byte: out_ch.last_byte,
                               command: out_ch.command, length: out_ch.length,
                               error_code: out_ch.error_code});
      end
      if (in_ch.valid && in_ch.ready) sb.note_item(in_ch.action, in_ch.byte_value);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("frame_header_hunt_deframer_unit_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item and returns at the edge where it is taken. The sender
  // works in bursts, dropping valid for a random gap between them.
  task automatic push_item(input logic act, input logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.byte_value <= val;
    burst_left--;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic push_byte(input logic [7:0] val);
    push_item(ACT_BYTE, val);
  endtask

  // The byte lane of a timeout is ignored by the block, so it carries noise.
  task automatic push_timeout();
    push_item(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  // Lets every outstanding result drain, then waits on for an item still in
  // flight that yields nothing.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] maj, input logic [7:0] minr,
                            input logic [7:0] tries, input logic [15:0] maxlen);
    write_reg(CFG_VERSION_MAJOR, {8'd0, maj});
    write_reg(CFG_VERSION_MINOR, {8'd0, minr});
    write_reg(CFG_MAX_TRIES, {8'd0, tries});
    write_reg(CFG_MAX_LENGTH, maxlen);
    cfg_we <= 1'b0;
  endtask

  // One frame attempt with random content: mostly well formed, with broken
  // headers, header restarts, bad lengths and timeouts mixed in.
  task automatic send_random_frame();
    int          hmode;
    int          lmode;
    int          k;
    int          p;
    int          n;
    logic [31:0] len;
    logic [31:0] limit;

    // Line noise ahead of the frame.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4))
        push_item(($urandom_range(0, 3) == 0) ? ACT_TIMEOUT : ACT_BYTE,
                  8'($urandom_range(0, 255)));
    end

    hmode = $urandom_range(0, 9);
    push_byte(SYNC_BYTE);
    if (hmode <= 1) begin
      // Header cut short by a wrong byte or a timeout.
      p = $urandom_range(0, 6);
      for (int i = 0; i < p; i++) push_byte(sb.header_byte(3'(i)));
      if (hmode == 0) push_byte(sb.header_byte(3'(p)) ^ 8'($urandom_range(1, 255)));
      else push_timeout();
      return;
    end
    if (hmode == 2) begin
      // Restarts, sometimes just at or one past the allowed number of attempts.
      if ($urandom_range(0, 2) == 0 && sb.max_tries <= 8'd12)
        k = int'(sb.max_tries) - 1 + $urandom_range(0, 1);
      else
        k = $urandom_range(1, 3);
      repeat (k) begin
        p = $urandom_range(0, 6);
        for (int i = 0; i < p; i++) push_byte(sb.header_byte(3'(i)));
        push_byte(SYNC_BYTE);
      end
    end
    for (int i = 0; i <= 6; i++) push_byte(sb.header_byte(3'(i)));

    limit = sb.len_limit();
    lmode = $urandom_range(0, 11);
    case (lmode)
      0:          len = 32'd0;
      1, 2, 3, 4: len = (limit == 32'd0) ? 32'd0 :
                        32'($urandom_range(1, (limit < 32'd6) ? limit : 6));
      5:          len = limit;
      6:          len = ($urandom_range(0, 1) == 0) ? limit + 32'd1 : {1'b0, 31'($urandom)};
      7:          len = LEN_NEG_ONE;
      8:          len = LEN_NEG_TWO;
      9:          len = {1'b1, 31'($urandom)};
      default:    len = $urandom;
    endcase

    if (lmode == 10) begin
      // Timeout part-way through the length field.
      p = $urandom_range(0, 3);
      for (int i = 0; i < p; i++) push_byte(len[8*i +: 8]);
      push_timeout();
      return;
    end
    for (int i = 0; i < 4; i++) push_byte(len[8*i +: 8]);
    if (!len[31] && len > limit) return;
    if (lmode == 11) begin
      push_timeout();
      return;
    end
    push_byte(8'($urandom_range(0, 255)));
    if (len[31] || len == 32'd0) return;

    // Long messages are abandoned by a timeout after a few bytes.
    n = (len > 32'd24) ? $urandom_range(0, 5) : int'(len);
    if (n == int'(len) && $urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
    if (n < int'(len)) push_timeout();
  endtask

  task automatic run_phase(input logic [7:0] maj, input logic [7:0] minr,
                           input logic [7:0] tries, input logic [15:0] maxlen,
                           input int count);
    int target;
    settle();
    set_config(maj, minr, tries, maxlen);
    target = items_sent + count;
    while (items_sent < target) send_random_frame();
  endtask

  initial begin
    sb = new(LENGTH_BITS);
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_BYTE;
    in_ch.byte_value <= 8'd0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_VERSION_MAJOR;
    cfg_data         <= 16'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at reset settings: a timeout and byte extremes while
    // hunting, then a header restarted once carrying a one-byte message.
    push_timeout();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_BYTE);
    push_byte(sb.header_byte(3'd0));
    push_byte(SYNC_BYTE);
    for (int i = 0; i <= 6; i++) push_byte(sb.header_byte(3'(i)));
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_timeout();

    // Random phases over several settings, extremes included. A minor
    // version equal to the sync byte means no header can ever complete.
    run_phase(8'd1, 8'd0, 8'd8, 16'd64, 200);
    run_phase(8'd0, 8'd255, 8'd1, 16'd0, 180);
    run_phase(8'd255, 8'd0, 8'd255, 16'd65535, 200);
    run_phase(8'($urandom_range(0, 255)), SYNC_BYTE, 8'd3, 16'd16, 60);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(2, 6)), 16'($urandom_range(1, 30)), 250);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)), 250);

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("frame_header_hunt_deframer_unit_test: PASS");
    end else begin
      $display("frame_header_hunt_deframer_unit_test: FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/fhd_pkg.sv
rtl/fhd_in_if.sv
rtl/fhd_out_if.sv
rtl/frame_header_hunt_deframer_unit.sv
verif/frame_header_hunt_deframer_unit_test.sv
